/* hdl/docking_pose_controller_macros.svh */
// ----------------------------------------------------------------------------
// docking_pose_controller_macros
// assertion macros for the docking pose controller
// ----------------------------------------------------------------------------
`ifndef DOCKING_POSE_CONTROLLER_MACROS_SVH
`define DOCKING_POSE_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge out of reset
`define DPC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("docking pose controller assertion failed");

// condition that must hold in the cycle after a trigger
`define DPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("docking pose controller assertion failed");

`else

`define DPC_ASSERT(lbl, prop)
`define DPC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hdl/dpc_pkg.sv */
// ----------------------------------------------------------------------------
// dpc_pkg
// types, constants and control program of the docking pose controller
// ----------------------------------------------------------------------------
`default_nettype none

package dpc_pkg;

    // beat, register and counter widths
    localparam int IN_W   = 48;
    localparam int OUT_W  = 32;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 16;
    localparam int STEP_W = 3;
    localparam int ITER_W = 4;

    // register indexes
    localparam logic [IDX_W-1:0] REG_DIST_GAIN  = 3'd0;
    localparam logic [IDX_W-1:0] REG_STEER_GAIN = 3'd1;
    localparam logic [IDX_W-1:0] REG_DIST_THR   = 3'd2;
    localparam logic [IDX_W-1:0] REG_ANGLE_THR  = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX_LIN    = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_ANG    = 3'd5;

    // register reset values
    localparam logic [15:0] DIST_GAIN_RST  = 16'd2048;
    localparam logic [15:0] STEER_GAIN_RST = 16'd12288;
    localparam logic [14:0] DIST_THR_RST   = 15'd205;
    localparam logic [14:0] ANGLE_THR_RST  = 15'd41;
    localparam logic [14:0] MAX_LIN_RST    = 15'd819;
    localparam logic [14:0] MAX_ANG_RST    = 15'd410;

    // angles in q.12
    localparam logic signed [16:0] PI_Q12     = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;

    // square root start: highest power of four below 2^32, sixteen digits
    localparam logic [31:0]       SQRT_BIT0  = 32'h4000_0000;
    localparam logic [ITER_W-1:0] SQRT_ITERS = 4'd15;

    localparam logic ACT_START = 1'b1;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_SQX,
        OP_SQY,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_LIN,
        OP_STEER,
        OP_ANG
    } op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_LOOP
    } seq_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        op_t   op;
        seq_t  seq;
        step_t target;
    } ctrl_t;

    // control program
    function automatic ctrl_t program_rom(input step_t step);
        ctrl_t w;
        case (step)
            3'd0:    w = '{op: OP_WAIT,      seq: SEQ_NEXT, target: 3'd0};
            3'd1:    w = '{op: OP_SQX,       seq: SEQ_NEXT, target: 3'd0};
            3'd2:    w = '{op: OP_SQY,       seq: SEQ_NEXT, target: 3'd0};
            3'd3:    w = '{op: OP_SQRT_INIT, seq: SEQ_NEXT, target: 3'd0};
            3'd4:    w = '{op: OP_SQRT_STEP, seq: SEQ_LOOP, target: 3'd4};
            3'd5:    w = '{op: OP_LIN,       seq: SEQ_NEXT, target: 3'd0};
            3'd6:    w = '{op: OP_STEER,     seq: SEQ_NEXT, target: 3'd0};
            3'd7:    w = '{op: OP_ANG,       seq: SEQ_JUMP, target: 3'd0};
            default: w = '{op: OP_WAIT,      seq: SEQ_JUMP, target: 3'd0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hdl/docking_pose_controller.sv */
// ----------------------------------------------------------------------------
// docking_pose_controller
// proportional docking controller run by a small microcoded sequencer
// ----------------------------------------------------------------------------
// A start beat (tuser = 1) puts the controller in moving mode and gives no
// result. A tick beat (tuser = 0) carries target offset x, y and yaw; while
// moving it yields one result beat with linear speed, angular speed and the
// moving flag after the tick, and idle ticks yield nothing. Each moving tick
// runs an 8-word program over one shared 17x17 signed multiplier and a
// one-digit-per-cycle square root. A tick holds the sequencer from its
// accept cycle through two squares, the root setup, sixteen root digits,
// then the linear, steering and output steps; the sixteen square root
// digits set most of that. The next beat can be taken at the earliest
// from the edge at which the result beat turns valid. Start beats and idle
// ticks leave the sequencer in its wait step. The result sits in an
// output register, so the next beat is accepted while a result still
// waits; only a second result stalls on a full output.
// Configuration writes are taken every cycle (cfg_ready is always high).
`default_nettype none

`include "docking_pose_controller_macros.svh"

module docking_pose_controller
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // input beats
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // offset_x[15:0], offset_y[31:16], yaw[47:32]
    input  wire logic [dpc_pkg::IN_W-1:0]      s_axis_tdata,
    // action[0]
    input  wire logic [0:0]                    s_axis_tuser,

    // result beats
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // linear_speed[14:0], angular_speed[30:15], still_moving[31]
    output logic [dpc_pkg::OUT_W-1:0]          m_axis_tdata,

    // register writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dpc_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [dpc_pkg::CFG_W-1:0]     cfg_data
);

    import dpc_pkg::*;

    // control state
    step_t             step_reg, step_next;
    logic [ITER_W-1:0] iter_reg;
    logic              moving_reg;
    logic              out_valid_reg;
    ctrl_t             ctrl;
    logic              stall;
    logic              in_accept;
    logic              out_accept;
    logic              run_tick;

    // configuration registers
    logic [15:0] dist_gain_reg;
    logic [15:0] steer_gain_reg;
    logic [14:0] dist_thr_reg;
    logic [14:0] angle_thr_reg;
    logic [14:0] max_lin_reg;
    logic [14:0] max_ang_reg;

    // datapath registers
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic signed [15:0] err_reg;
    logic [31:0]        acc_reg;
    logic [31:0]        root_reg;
    logic [31:0]        bit_reg;
    logic [15:0]        dist_reg;
    logic               near_reg;
    logic [14:0]        lin_reg;
    logic signed [21:0] steer_reg;
    logic [14:0]        out_lin_reg;
    logic signed [15:0] out_ang_reg;
    logic               out_moving_reg;

    // datapath nets
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] prod;
    logic signed [16:0] yaw_in;
    logic signed [16:0] yaw_wrap;
    logic signed [16:0] neg_yaw;
    logic [32:0]        trial;
    logic               take_digit;
    logic [20:0]        lin_q;
    logic signed [22:0] ang_full;
    logic signed [22:0] amax;
    logic signed [15:0] ang_clamped;
    logic signed [16:0] err_abs;
    logic               settle;

    assign ctrl       = program_rom(step_reg);
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;
    assign run_tick   = in_accept && (s_axis_tuser[0] != ACT_START) && moving_reg;

    assign s_axis_tready = (ctrl.op == OP_WAIT);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_moving_reg, out_ang_reg, out_lin_reg};

    // hold in wait until a moving tick, hold the last step on a full output
    always_comb
    begin
        case (ctrl.op)
            OP_WAIT: stall = !run_tick;
            OP_ANG:  stall = out_valid_reg && !m_axis_tready;
            default: stall = 1'b0;
        endcase
    end

    always_comb
    begin
        if (stall)
        begin
            step_next = step_reg;
        end
        else
        begin
            case (ctrl.seq)
                SEQ_JUMP: step_next = ctrl.target;
                SEQ_LOOP: step_next = (iter_reg != '0) ? ctrl.target : step_reg + 1'b1;
                default:  step_next = step_reg + 1'b1;
            endcase
        end
    end

    // shared multiplier operand selection
    always_comb
    begin
        case (ctrl.op)
            OP_SQX:
            begin
                mul_a = 17'(x_reg);
                mul_b = 17'(x_reg);
            end
            OP_SQY:
            begin
                mul_a = 17'(y_reg);
                mul_b = 17'(y_reg);
            end
            OP_LIN:
            begin
                mul_a = $signed({1'b0, dist_gain_reg});
                mul_b = $signed({1'b0, dist_reg});
            end
            OP_STEER:
            begin
                mul_a = $signed({1'b0, steer_gain_reg});
                mul_b = -17'(y_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 34'(mul_a) * 34'(mul_b);

    // yaw wrap into (-pi, pi]: one correction covers the whole input range
    assign yaw_in   = 17'($signed(s_axis_tdata[47:32]));
    assign yaw_wrap = (yaw_in > PI_Q12)   ? yaw_in - TWO_PI_Q12 :
                      (yaw_in <= -PI_Q12) ? yaw_in + TWO_PI_Q12 : yaw_in;
    assign neg_yaw  = -yaw_wrap;

    // one square root digit
    assign trial      = {1'b0, root_reg} + {1'b0, bit_reg};
    assign take_digit = {1'b0, acc_reg} >= trial;

    // linear speed, product is never negative here
    assign lin_q = prod[32:12];

    // angular speed at full width, then symmetric clamp
    assign amax     = $signed({8'd0, max_ang_reg});
    assign ang_full = near_reg ? 23'(err_reg) : 23'(steer_reg) + 23'(err_reg);
    always_comb
    begin
        if (ang_full > amax)
        begin
            ang_clamped = 16'(amax);
        end
        else if (ang_full < -amax)
        begin
            ang_clamped = 16'(-amax);
        end
        else
        begin
            ang_clamped = 16'(ang_full);
        end
    end

    assign err_abs = (err_reg < 0) ? -17'(err_reg) : 17'(err_reg);
    assign settle  = near_reg && (err_abs < $signed({2'b00, angle_thr_reg}));

    // sequencer, mode and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            iter_reg      <= '0;
            moving_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (ctrl.op == OP_SQRT_INIT)
            begin
                iter_reg <= SQRT_ITERS;
            end
            else if (ctrl.op == OP_SQRT_STEP)
            begin
                iter_reg <= iter_reg - 1'b1;
            end
            if (in_accept && (s_axis_tuser[0] == ACT_START))
            begin
                moving_reg <= 1'b1;
            end
            else if ((ctrl.op == OP_ANG) && !stall && settle)
            begin
                moving_reg <= 1'b0;
            end
            if ((ctrl.op == OP_ANG) && !stall)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // configuration registers, extra bits dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_gain_reg  <= DIST_GAIN_RST;
            steer_gain_reg <= STEER_GAIN_RST;
            dist_thr_reg   <= DIST_THR_RST;
            angle_thr_reg  <= ANGLE_THR_RST;
            max_lin_reg    <= MAX_LIN_RST;
            max_ang_reg    <= MAX_ANG_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DIST_GAIN:  dist_gain_reg  <= cfg_data;
                REG_STEER_GAIN: steer_gain_reg <= cfg_data;
                REG_DIST_THR:   dist_thr_reg   <= cfg_data[14:0];
                REG_ANGLE_THR:  angle_thr_reg  <= cfg_data[14:0];
                REG_MAX_LIN:    max_lin_reg    <= cfg_data[14:0];
                REG_MAX_ANG:    max_ang_reg    <= cfg_data[14:0];
                default:        ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_WAIT:
            begin
                if (in_accept)
                begin
                    x_reg   <= $signed(s_axis_tdata[15:0]);
                    y_reg   <= $signed(s_axis_tdata[31:16]);
                    err_reg <= 16'(neg_yaw);
                end
            end
            OP_SQX:
            begin
                acc_reg <= prod[31:0];
            end
            OP_SQY:
            begin
                acc_reg <= acc_reg + prod[31:0];
            end
            OP_SQRT_INIT:
            begin
                root_reg <= '0;
                bit_reg  <= SQRT_BIT0;
            end
            OP_SQRT_STEP:
            begin
                if (take_digit)
                begin
                    acc_reg  <= acc_reg - trial[31:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_LIN:
            begin
                near_reg <= dist_reg < {1'b0, dist_thr_reg};
                if (lin_q > {6'd0, max_lin_reg})
                begin
                    lin_reg <= max_lin_reg;
                end
                else
                begin
                    lin_reg <= lin_q[14:0];
                end
            end
            OP_STEER:
            begin
                steer_reg <= prod[33:12];
            end
            OP_ANG:
            begin
                if (!stall)
                begin
                    out_lin_reg    <= near_reg ? 15'd0 : lin_reg;
                    out_ang_reg    <= ang_clamped;
                    out_moving_reg <= !settle;
                end
            end
            default: ;
        endcase
        // root is final once the loop step is left
        if ((ctrl.op == OP_SQRT_STEP) && (iter_reg == '0))
        begin
            dist_reg <= take_digit ? 16'((root_reg >> 1) + bit_reg) : 16'(root_reg >> 1);
        end
    end

    // a result only ever comes out of the last program step
    `DPC_ASSERT(a_result_from_last_step, !$rose(out_valid_reg) || ($past(ctrl.op) == OP_ANG))

    // the square root loop ends after its last digit
    `DPC_ASSERT_NEXT(a_sqrt_loop_exit, (ctrl.op == OP_SQRT_STEP) && (iter_reg == '0), ctrl.op == OP_LIN)

    // a start beat always leaves the block moving
    `DPC_ASSERT_NEXT(a_start_sets_moving, in_accept && (s_axis_tuser[0] == ACT_START), moving_reg)

endmodule

`default_nettype wire

/* tb/tb_docking_pose_controller.sv */
// ----------------------------------------------------------------------------
// tb_docking_pose_controller
// self-checking bench for the docking pose controller
// ----------------------------------------------------------------------------
// Drives start and tick beats into the controller and predicts every speed
// command from the offsets, the yaw and the current register settings. Each
// result beat is checked field by field against the oldest prediction. Five
// phases run under different register settings and handshake idling patterns.
// One phase holds the result side off for a long stretch so the controller
// backs up into its input.

module tb_docking_pose_controller;

    import dpc_pkg::*;

    // action code of a control tick, the opposite of a start command
    localparam logic ACT_TICK = !ACT_START;

    // register indexes past the end of the map, writes must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // margin long enough to cover a moving tick still in flight
    localparam int DRAIN_CYCLES = 40;
    // long result-side hold-off so the output register and the input back up
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_BEATS  = 225;
    localparam int LIMIT_CYCLES = 600000;

    // one predicted speed command
    typedef struct {
        logic [14:0] lin;
        logic [15:0] ang;
        logic        still;
    } speed_cmd_t;

    // ------------------------------------------------------------------------
    // predictor and check of the speed commands
    // ------------------------------------------------------------------------
    class speed_command_book;
        logic [15:0] dist_gain;
        logic [15:0] steer_gain;
        logic [14:0] dist_thr;
        logic [14:0] angle_thr;
        logic [14:0] lin_max;
        logic [14:0] ang_max;
        bit          moving;
        speed_cmd_t  expected_cmds[$];
        int          errors;

        function new();
            dist_gain  = DIST_GAIN_RST;
            steer_gain = STEER_GAIN_RST;
            dist_thr   = DIST_THR_RST;
            angle_thr  = ANGLE_THR_RST;
            lin_max    = MAX_LIN_RST;
            ang_max    = MAX_ANG_RST;
            moving     = 1'b0;
            errors     = 0;
        endfunction

        // register write, upper bit of the narrow registers is dropped
        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_DIST_GAIN:  dist_gain  = value;
                REG_STEER_GAIN: steer_gain = value;
                REG_DIST_THR:   dist_thr   = value[14:0];
                REG_ANGLE_THR:  angle_thr  = value[14:0];
                REG_MAX_LIN:    lin_max    = value[14:0];
                REG_MAX_ANG:    ang_max    = value[14:0];
                default: ;
            endcase
        endfunction

        // floor of the square root, one result bit at a time from the top
        function int unsigned floor_root(longint unsigned v);
            int unsigned     r;
            longint unsigned t;
            r = 0;
            for (int b = 15; b >= 0; b--)
            begin
                t = r | (32'd1 << b);
                if (t * t <= v)
                    r = t;
            end
            return r;
        endfunction

        // accepted input beat: update the mode and predict the command
        function void take_pose(logic act, logic signed [15:0] x,
                                logic signed [15:0] y, logic signed [15:0] yaw);
            longint     sx;
            longint     sy;
            longint     head;
            longint     err;
            longint     span;
            longint     lin;
            longint     ang;
            speed_cmd_t c;
            if (act == ACT_START)
            begin
                moving = 1'b1;
                return;
            end
            if (!moving)
                return;
            sx   = x;
            sy   = y;
            head = yaw;
            span = floor_root(sx * sx + sy * sy);
            while (head > PI_Q12)
                head -= TWO_PI_Q12;
            while (head <= -PI_Q12)
                head += TWO_PI_Q12;
            err = -head;
            if (span >= longint'(dist_thr))
            begin
                // arithmetic shift floors the gain products
                lin = (longint'(dist_gain) * span) >>> 12;
                if (lin > longint'(lin_max))
                    lin = longint'(lin_max);
                ang = ((longint'(steer_gain) * -sy) >>> 12) + err;
            end
            else
            begin
                lin = 0;
                ang = err;
                if ((err < 0 ? -err : err) < longint'(angle_thr))
                    moving = 1'b0;
            end
            if (ang > longint'(ang_max))
                ang = longint'(ang_max);
            if (ang < -longint'(ang_max))
                ang = -longint'(ang_max);
            c.lin   = lin[14:0];
            c.ang   = ang[15:0];
            c.still = moving;
            expected_cmds.insert(expected_cmds.size(), c);
        endfunction

        function void check_command(logic [OUT_W-1:0] got);
            speed_cmd_t want;
            if (expected_cmds.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_cmds.pop_front();
            if (got[14:0] !== want.lin)
            begin
                $display("%0t: linear_speed expected %0d actual %0d",
                         $time, want.lin, got[14:0]);
                errors++;
            end
            if (got[30:15] !== want.ang)
            begin
                $display("%0t: angular_speed expected %0d actual %0d",
                         $time, $signed(want.ang), $signed(got[30:15]));
                errors++;
            end
            if (got[31] !== want.still)
            begin
                $display("%0t: still_moving expected %b actual %b",
                         $time, want.still, got[31]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block signals
    // ------------------------------------------------------------------------
    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]       s_axis_tuser  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             cfg_valid     = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0] cfg_data      = '0;

    // idling odds in percent per cycle, set per phase
    int               tx_idle_pct   = 0;
    int               rx_idle_pct   = 0;
    // long hold-off request from the stimulus side, served once
    logic             pressure_req  = 1'b0;
    logic             pressure_done = 1'b0;
    int               hold_left     = 0;
    int               beats_sent    = 0;

    speed_command_book sb;

    always #4 clk = ~clk;

    docking_pose_controller uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // result side: check accepted beats and randomize tready
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_command(m_axis_tdata);
        if (hold_left > 0)
        begin
            // long stall, counted here so the sender keeps offering beats
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (pressure_req && !pressure_done)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one input beat, with random idle cycles in front of it
    task automatic send_beat(input logic act, input logic signed [15:0] x,
                             input logic signed [15:0] y,
                             input logic signed [15:0] yaw);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {yaw, y, x};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.take_pose(act, x, y, yaw);
        beats_sent++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] dg, input logic [15:0] sg,
                                input logic [15:0] dt, input logic [15:0] at,
                                input logic [15:0] ml, input logic [15:0] ma);
        write_reg(REG_DIST_GAIN, dg);
        write_reg(REG_STEER_GAIN, sg);
        write_reg(REG_DIST_THR, dt);
        write_reg(REG_ANGLE_THR, at);
        write_reg(REG_MAX_LIN, ml);
        write_reg(REG_MAX_ANG, ma);
    endtask

    // stop offering, wait for every predicted command, then let the
    // sequencer finish whatever no-result beat it may still hold
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_offset();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(0, 1024)) - 512);
            2: return 16'(int'($urandom_range(0, 16384)) - 8192);
            default:
                case ($urandom_range(3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return 16'sh0000;
                    default: return 16'shffff;
                endcase
        endcase
    endfunction

    // mostly within two pi, now and then any 16-bit value to exercise wrapping
    function automatic logic signed [15:0] rand_yaw();
        if ($urandom_range(19) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 51472)) - 25736);
    endfunction

    function automatic logic signed [15:0] near_offset();
        return 16'(int'($urandom_range(0, 200)) - 100);
    endfunction

    function automatic logic signed [15:0] scaled(logic signed [15:0] v,
                                                  int num, int den);
        return 16'(int'(v) * num / den);
    endfunction

    // start, approach along a shrinking offset, then turn on the spot
    // until the heading settles; some runs break off early
    task automatic docking_run();
        int                 n;
        int                 k;
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] yaw0;
        logic signed [15:0] yaw_near;
        n        = $urandom_range(2, 10);
        x0       = rand_offset();
        y0       = rand_offset();
        yaw0     = rand_yaw();
        yaw_near = rand_yaw();
        k        = $urandom_range(1, 5);
        send_beat(ACT_START, rand_offset(), rand_offset(), rand_yaw());
        for (int i = 0; i < n; i++)
            send_beat(ACT_TICK, scaled(x0, n - i, n), scaled(y0, n - i, n),
                      scaled(yaw0, n - i, n));
        if ($urandom_range(9) < 2)
            return;
        for (int j = 0; j <= k; j++)
            send_beat(ACT_TICK, near_offset(), near_offset(),
                      (j == k) ? 16'sh0000 : (yaw_near >>> j));
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at)
        begin
            if ($urandom_range(99) < 80)
                docking_run();
            else
                send_beat(($urandom_range(4) == 0) ? ACT_START : ACT_TICK,
                          rand_offset(), rand_offset(), rand_yaw());
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n       <= 1'b1;
        tx_idle_pct <= 14;
        rx_idle_pct <= 80;
        @(posedge clk);

        // writes past the register map must leave the defaults alone
        write_reg(REG_SPARE_LO, 16'hffff);
        write_reg(REG_SPARE_HI, 16'h0000);

        // directed beats under the default settings
        send_beat(ACT_TICK, 16'sd1000, -16'sd1000, 16'sd5000);      // idle tick
        send_beat(ACT_START, 16'sh0000, 16'sh0000, 16'sh0000);
        send_beat(ACT_START, 16'shffff, 16'shffff, 16'shffff);      // start while moving
        send_beat(ACT_TICK, 16'sh7fff, 16'sh7fff, 16'sh0000);       // both clamps
        send_beat(ACT_TICK, 16'sh8000, 16'sh8000, 16'sd25736);
        send_beat(ACT_TICK, 16'sd205, 16'sh0000, -16'sd25736);      // exactly at threshold
        send_beat(ACT_TICK, 16'sd204, 16'sh0000, 16'sd12868);       // just inside, yaw pi
        send_beat(ACT_TICK, 16'sh0000, 16'sh0000, -16'sd12868);     // minus pi wraps
        send_beat(ACT_TICK, 16'sh0000, 16'sh0000, 16'sh7fff);       // beyond two pi
        send_beat(ACT_TICK, 16'sh0000, 16'sh0000, 16'sh8000);
        send_beat(ACT_TICK, 16'sh0000, 16'sh0000, 16'sd41);         // error at threshold
        send_beat(ACT_TICK, 16'sd3, -16'sd4, -16'sd40);             // settles, goes idle
        send_beat(ACT_TICK, 16'sh8000, 16'sh7fff, 16'sh8000);       // ignored while idle
        send_beat(ACT_START, 16'sh0000, 16'sh0000, 16'sh0000);
        send_beat(ACT_TICK, 16'sh0000, 16'sh8000, 16'sh0000);       // positive turn clamp
        send_beat(ACT_TICK, -16'sd1, -16'sd1, -16'sd1);             // settles at once
        send_beat(ACT_START, 16'sh0000, 16'sh0000, 16'sh0000);
        send_beat(ACT_TICK, 16'sd100, 16'sd150, 16'sd200);
        send_beat(ACT_TICK, 16'sd4096, -16'sd4096, 16'sd100);
        send_beat(ACT_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
        run_random(PHASE_BEATS);
        wait_drain();

        // top distance gain and clamps, zero steering gain and thresholds: never settles
        program_regs(16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff);
        tx_idle_pct <= 80;
        rx_idle_pct <= 14;
        run_random(PHASE_BEATS);
        wait_drain();

        // zero distance gain and clamps, thresholds written with the
        // upper bit set so only the low 15 bits must survive
        program_regs(16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h8000);
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        run_random(PHASE_BEATS);
        wait_drain();

        // random mid-range settings with a long result stall
        program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(50, 2000)), 16'($urandom_range(1, 3000)),
                     16'($urandom_range(1, 32767)), 16'($urandom_range(1, 32767)));
        pressure_req <= 1'b1;
        run_random(PHASE_BEATS);
        wait_drain();

        // moderate settings where both speeds move inside their clamps
        program_regs(16'd4096, 16'd8192, 16'd400, 16'd100, 16'd4000, 16'd3000);
        run_random(PHASE_BEATS);
        wait_drain();

        if (sb.errors == 0)
            $display("docking_pose_controller test passed");
        else
            $display("docking_pose_controller test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(8 * LIMIT_CYCLES);
        $display("docking_pose_controller test failed");
        $finish;
    end

endmodule
